// ===== rtl/core/rtc_three_wire_datetime_master_macros.svh =====
// Assertion macros shared by the three-wire clock master RTL.
// Included by rtc3w_skid.sv and rtc_three_wire_datetime_master.sv; no other dependencies.
`ifndef RTC_THREE_WIRE_DATETIME_MASTER_MACROS_SVH
`define RTC_THREE_WIRE_DATETIME_MASTER_MACROS_SVH
`ifndef SYNTH
`define RTC3W_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtc3w same-cycle check failed");
`define RTC3W_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtc3w next-cycle check failed");
`else
`define RTC3W_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RTC3W_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/rtc3w_pkg.sv =====
// Types, register addresses and BCD helpers for the three-wire clock master.
// No dependencies; used by rtc3w_skid and the top level.
`default_nettype none
package rtc3w_pkg;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_INIT = 2'd1,
    CMD_SET  = 2'd2,
    CMD_GET  = 2'd3
  } rtc3w_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] year_in;
    logic [6:0] month_in;
    logic [6:0] day_in;
    logic [6:0] hour_in;
    logic [6:0] minute_in;
    logic [6:0] second_in;
    logic       io_in;
  } rtc3w_req_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] year_out;
    logic [7:0] month_out;
    logic [7:0] day_out;
    logic [7:0] hour_out;
    logic [7:0] minute_out;
    logic [7:0] second_out;
  } rtc3w_res_t;

  localparam logic [7:0] ADDR_WP       = 8'h8E;
  localparam logic [7:0] READ_FLAG     = 8'h01;
  localparam logic [7:0] WP_OFF        = 8'h00;
  localparam logic [7:0] WP_ON         = 8'h80;
  localparam logic [7:0] INIT_DATA     = 8'h00;
  localparam logic [3:0] FRAMES_INIT   = 4'd2;
  localparam logic [3:0] FRAMES_SET    = 4'd8;
  localparam logic [3:0] FRAMES_GET    = 4'd6;
  localparam logic [4:0] BITS_PER_FRAME = 5'd16;

  // Time-keeping register addresses, second through year.
  function automatic logic [7:0] reg_addr(input logic [2:0] idx);
    logic [7:0] a;
    case (idx)
      3'd0:    a = 8'h80;
      3'd1:    a = 8'h82;
      3'd2:    a = 8'h84;
      3'd3:    a = 8'h86;
      3'd4:    a = 8'h88;
      default: a = 8'h8C;
    endcase
    return a;
  endfunction

  // Binary to BCD: tens by reciprocal multiply (exact for 7-bit values).
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [3:0]  ones;
    prod     = 15'(v) * 15'd205;
    tens     = prod[14:11];
    tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
    ones     = 4'(v - tens_x10);
    return {tens, ones};
  endfunction

  // BCD to binary, no masking of the high nibble.
  function automatic logic [7:0] from_bcd(input logic [7:0] t);
    return {1'b0, t[7:4], 3'b000} + {3'b000, t[7:4], 1'b0} + {4'b0000, t[3:0]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rtc3w_skid.sv =====
// Two-entry result buffer: output register plus one skid slot.
// Depends on rtc3w_pkg and the assertion macro header.
`default_nettype none
`include "rtc_three_wire_datetime_master_macros.svh"
module rtc3w_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  input  rtc3w_pkg::rtc3w_res_t push_data,
  output logic                 push_stall,
  output logic                 out_valid,
  output rtc3w_pkg::rtc3w_res_t out_data,
  input  logic                 out_stall
);
  import rtc3w_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  logic       full_r, full_nxt;
  rtc3w_res_t out_r, out_nxt;
  rtc3w_res_t skid_r, skid_nxt;
  logic       push;
  logic       pop;

  assign push = push_valid && !full_r;
  assign pop  = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    full_nxt      = full_r;
    out_nxt       = out_r;
    skid_nxt      = skid_r;
    if (!out_valid_r || pop) begin
      // output slot frees: refill from skid first, else from the new request
      out_valid_nxt = full_r || push;
      out_nxt       = full_r ? skid_r : push_data;
      full_nxt      = 1'b0;
    end else if (push) begin
      skid_nxt = push_data;
      full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      full_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      full_r      <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign push_stall = full_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  `RTC3W_ASSERT_IMPL(a_full_has_out, clk, rst_n, full_r, out_valid_r)
  `RTC3W_ASSERT_NEXT(a_full_drains, clk, rst_n, full_r && !out_stall, !full_r)
  `RTC3W_ASSERT_NEXT(a_push_to_skid, clk, rst_n, push && out_valid_r && out_stall, full_r)

endmodule
`default_nettype wire

// ===== rtl/core/rtc_three_wire_datetime_master.sv =====
// Top level of the three-wire real-time clock master: frame sequencer and readings.
// Depends on rtc3w_pkg, rtc3w_skid and the assertion macro header.
//
// Usage:
//  - in_valid/in_stall/in_data carry one request per serial-clock half-period tick.
//    in_data.cmd starts a sequence when idle (init, set, get); it is ignored while busy.
//    The set fields are captured only on the tick that accepts a set command.
//  - out_valid/out_stall/out_data return exactly one result per request: pin levels
//    (CE, SCLK, data out, data drive enable), busy/done flags and six decoded readings.
//  - Each result is registered in the result buffer when its request is accepted.
//  - Throughput: one request per cycle while in_stall is low; the sequencer state
//    advances on each accepted request through one short pass of next-state logic.
//  - Each frame spans 34 ticks; init is 2 frames, set 8 frames, get 6 frames.
//  - Reset (rst_n low, synchronous) returns the sequencer to idle, clears the readings
//    and empties the result buffer. Captured set values are not cleared.
//  - When the receiver stalls, the output register holds; one more result fits in the
//    skid slot, after which in_stall rises until the output drains.
`default_nettype none
`include "rtc_three_wire_datetime_master_macros.svh"
module rtc_three_wire_datetime_master (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rtc3w_pkg::rtc3w_req_t in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rtc3w_pkg::rtc3w_res_t out_data
);
  import rtc3w_pkg::*;

  // sequencer state
  rtc3w_cmd_t kind_r, kind_nxt;
  logic [3:0] frame_r, frame_nxt;
  logic [4:0] bit_r, bit_nxt;
  logic       phase_r, phase_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [6:0] latched_r [6];
  logic [7:0] dec_r [6];
  logic [7:0] dec_nxt [6];

  // working values after a possible command start
  logic       in_acc;
  logic       start;
  rtc3w_cmd_t kind_c;
  logic [3:0] frame_c;
  logic [4:0] bit_c;
  logic       phase_c;
  logic [7:0] shift_c;
  logic [3:0] nframes;
  logic [7:0] addr;
  logic [7:0] data;
  logic [7:0] cur_byte;
  logic       rd;
  logic [2:0] lat_idx;
  logic [2:0] get_idx;
  rtc3w_res_t res_c;

  assign in_acc = in_valid && !in_stall;
  assign start  = (kind_r == CMD_TICK) && (rtc3w_cmd_t'(in_data.cmd) != CMD_TICK);

  always_comb begin
    kind_c  = start ? rtc3w_cmd_t'(in_data.cmd) : kind_r;
    frame_c = start ? 4'd0 : frame_r;
    bit_c   = start ? 5'd0 : bit_r;
    phase_c = start ? 1'b0 : phase_r;
    shift_c = start ? 8'd0 : shift_r;

    // set frames one through six carry the captured values
    lat_idx = ((frame_c == 4'd0) || (frame_c > 4'd6)) ? 3'd0 : 3'(frame_c - 4'd1);
    get_idx = (frame_c > 4'd5) ? 3'd5 : frame_c[2:0];

    nframes = FRAMES_GET;
    addr    = ADDR_WP;
    data    = INIT_DATA;
    rd      = 1'b0;
    case (kind_c)
      CMD_INIT: begin
        nframes = FRAMES_INIT;
        addr    = (frame_c == 4'd0) ? ADDR_WP : reg_addr(3'd0);
        data    = INIT_DATA;
      end
      CMD_SET: begin
        nframes = FRAMES_SET;
        if (frame_c == 4'd0) begin
          addr = ADDR_WP;
          data = WP_OFF;
        end else if (frame_c >= 4'd7) begin
          addr = ADDR_WP;
          data = WP_ON;
        end else begin
          addr = reg_addr(lat_idx);
          data = to_bcd(latched_r[lat_idx]);
        end
      end
      CMD_GET: begin
        nframes = FRAMES_GET;
        addr    = reg_addr(get_idx) | READ_FLAG;
        rd      = 1'b1;
      end
      default: begin
        nframes = FRAMES_GET;
      end
    endcase

    kind_nxt  = kind_c;
    frame_nxt = frame_c;
    bit_nxt   = bit_c;
    phase_nxt = phase_c;
    shift_nxt = shift_c;
    for (int i = 0; i < 6; i++) begin
      dec_nxt[i] = dec_r[i];
    end
    cur_byte = bit_c[3] ? data : addr;
    res_c    = '0;

    if (kind_c != CMD_TICK) begin
      res_c.busy_res = 1'b1;
      if (bit_c < BITS_PER_FRAME) begin
        res_c.chip_enable  = 1'b1;
        res_c.serial_clock = phase_c;
        if (!bit_c[3] || !rd) begin
          res_c.io_drive = 1'b1;
          res_c.io_out   = cur_byte[bit_c[2:0]];
        end else if (!phase_c) begin
          // sample the line before the rising edge, LSB first
          shift_nxt = {in_data.io_in, shift_c[7:1]};
        end
      end else if (!phase_c) begin
        // closing falling edge; store the byte just read
        res_c.chip_enable = 1'b1;
        if (rd) begin
          dec_nxt[get_idx] = from_bcd(shift_c);
        end
      end

      if (!phase_c) begin
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        if (bit_c < BITS_PER_FRAME) begin
          bit_nxt = bit_c + 5'd1;
        end else begin
          bit_nxt   = 5'd0;
          shift_nxt = 8'd0;
          frame_nxt = frame_c + 4'd1;
          if (frame_nxt >= nframes) begin
            res_c.done_res = 1'b1;
            kind_nxt       = CMD_TICK;
            frame_nxt      = 4'd0;
          end
        end
      end
    end

    res_c.second_out = dec_nxt[0];
    res_c.minute_out = dec_nxt[1];
    res_c.hour_out   = dec_nxt[2];
    res_c.day_out    = dec_nxt[3];
    res_c.month_out  = dec_nxt[4];
    res_c.year_out   = dec_nxt[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= CMD_TICK;
      frame_r <= 4'd0;
      bit_r   <= 5'd0;
      phase_r <= 1'b0;
      shift_r <= 8'd0;
      for (int i = 0; i < 6; i++) begin
        dec_r[i] <= 8'd0;
      end
    end else if (in_acc) begin
      kind_r  <= kind_nxt;
      frame_r <= frame_nxt;
      bit_r   <= bit_nxt;
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      for (int i = 0; i < 6; i++) begin
        dec_r[i] <= dec_nxt[i];
      end
    end
  end

  // capture the set values only on the request that starts a set sequence
  always_ff @(posedge clk) begin
    if (in_acc && start && (rtc3w_cmd_t'(in_data.cmd) == CMD_SET)) begin
      latched_r[0] <= in_data.second_in;
      latched_r[1] <= in_data.minute_in;
      latched_r[2] <= in_data.hour_in;
      latched_r[3] <= in_data.day_in;
      latched_r[4] <= in_data.month_in;
      latched_r[5] <= in_data.year_in;
    end
  end

  rtc3w_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(in_valid),
    .push_data (res_c),
    .push_stall(in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  `RTC3W_ASSERT_IMPL(a_bit_range, clk, rst_n, kind_r != CMD_TICK, bit_r <= BITS_PER_FRAME)
  `RTC3W_ASSERT_NEXT(a_hold_no_req, clk, rst_n, !in_acc, $stable(kind_r))
  `RTC3W_ASSERT_NEXT(a_done_idle, clk, rst_n, in_acc && res_c.done_res, kind_r == CMD_TICK)
  `RTC3W_ASSERT_IMPL(a_release_low, clk, rst_n, out_valid && !out_data.io_drive, !out_data.io_out)

endmodule
`default_nettype wire
